@@ hw/rtl/ufc_pkg.sv @@
`timescale 1ns / 1ps
package ufc_pkg;

  // Frame layout and check constants
  localparam int unsigned HDR_BYTES        = 20;
  localparam int unsigned COUNT_BITS       = 17;
  localparam logic [16:0] COUNT_MAX        = 17'h1FFFF;
  localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
  localparam logic [7:0]  FRAME_MAGIC      = 8'h5A;
  localparam int unsigned COUNTER_BITS_DEF = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD  = 1'd1;
  localparam logic        CHECK_ENABLE_RST = 1'b1;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1400;

  // Verdict codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_CRC_MISMATCH = 3'd5,
    ST_NO_CONV_ID  = 3'd6
  } status_t;

  typedef struct packed {
    logic        check_enable;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] session_id;
    logic [31:0] conversation_id;
    logic [15:0] payload_length;
    logic [31:0] pass_count;
    logic [31:0] fail_count;
  } result_t;

  // One byte of reflected CRC-32, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    c = crc ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/udp_frame_checker.sv @@
`timescale 1ns / 1ps
// Datagram frame checker. Bytes enter one per cycle on the in_ channel while
// in_stall is low, with in_last_byte marking the end of a datagram; one verdict
// per datagram leaves on the out_ channel. Each byte is held in the input
// register, where the byte-wide CRC-32 update and header capture run, and a
// verdict is loaded into the output register as the last byte leaves the input
// register. Sustained rate is one byte per clock; a last byte waits in the input
// register only while an earlier verdict is still stalled at the output. With
// check_enable set, the datagram carries a 20-byte little-endian header (magic
// 0x5A, length, session, stored CRC) whose CRC covers header bytes 0-15 and the
// payload. Pass and fail counters are COUNTER_BITS wide and wrap; their low 32
// bits are reported. Write configuration only while no datagram is in flight.
module udp_frame_checker #(
  parameter int unsigned COUNTER_BITS = ufc_pkg::COUNTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [ufc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ufc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  // byte input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  // verdict output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_status,
  output logic [31:0]                        out_session_id,
  output logic [31:0]                        out_conversation_id,
  output logic [15:0]                        out_payload_length,
  output logic [31:0]                        out_pass_count,
  output logic [31:0]                        out_fail_count
);
  import ufc_pkg::*;

  cfg_t    cfg;
  result_t verdict;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       out_free;
  logic       byte_go;
  logic       in_take;
  logic       out_load;

  ufc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ufc_frame_parse #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_go   (byte_go),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .result    (verdict)
  );

  // Flow control: a last byte needs room in the output register
  assign out_free  = !out_valid_r || !out_stall;
  assign byte_go   = in_valid_r && (!in_last_r || out_free);
  assign in_stall  = in_valid_r && !byte_go;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = byte_go && in_last_r;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (byte_go ? 1'b0 : in_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (out_load) begin
      out_res_r <= verdict;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_session_id      = out_res_r.session_id;
  assign out_conversation_id = out_res_r.conversation_id;
  assign out_payload_length  = out_res_r.payload_length;
  assign out_pass_count      = out_res_r.pass_count;
  assign out_fail_count      = out_res_r.fail_count;

endmodule

@@ hw/rtl/ufc_cfg_regs.sv @@
`timescale 1ns / 1ps
module ufc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ufc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ufc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output ufc_pkg::cfg_t                       cfg
);
  import ufc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_ENABLE: cfg_nxt.check_enable = cfg_wdata[0];
        CFG_MAX_PAYLOAD:  cfg_nxt.max_payload  = cfg_wdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable <= CHECK_ENABLE_RST;
      cfg_r.max_payload  <= MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/ufc_frame_parse.sv @@
`timescale 1ns / 1ps
module ufc_frame_parse #(
  parameter int unsigned COUNTER_BITS = ufc_pkg::COUNTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ufc_pkg::cfg_t    cfg,
  input  logic             byte_go,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output ufc_pkg::result_t result
);
  import ufc_pkg::*;

  logic [16:0] byte_cnt_r, byte_cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  magic_r, magic_nxt;
  logic [15:0] hdr_len_r, hdr_len_nxt;
  logic [31:0] hdr_sess_r, hdr_sess_nxt;
  logic [31:0] stored_crc_r, stored_crc_nxt;
  logic [31:0] conv_r, conv_nxt;
  logic [COUNTER_BITS-1:0] pass_r, pass_nxt;
  logic [COUNTER_BITS-1:0] fail_r, fail_nxt;

  logic [16:0] pos;
  logic [16:0] total;
  logic [16:0] plen_full;
  logic [16:0] max_total;
  logic [16:0] len_total;
  logic        conv_hit;
  logic [1:0]  conv_lane;
  logic [COUNTER_BITS+31:0] pass_ext, fail_ext;

  assign pos = byte_cnt_r;

  // Header field capture and CRC update for the current byte
  always_comb begin
    magic_nxt      = magic_r;
    hdr_len_nxt    = hdr_len_r;
    hdr_sess_nxt   = hdr_sess_r;
    stored_crc_nxt = stored_crc_r;
    conv_nxt       = conv_r;
    crc_nxt        = crc_r;

    if (pos == 17'd0) magic_nxt = data_byte;
    if (pos == 17'd2) hdr_len_nxt[7:0]  = data_byte;
    if (pos == 17'd3) hdr_len_nxt[15:8] = data_byte;
    if (pos == 17'd4) hdr_sess_nxt[7:0]   = data_byte;
    if (pos == 17'd5) hdr_sess_nxt[15:8]  = data_byte;
    if (pos == 17'd6) hdr_sess_nxt[23:16] = data_byte;
    if (pos == 17'd7) hdr_sess_nxt[31:24] = data_byte;
    if (pos == 17'd16) stored_crc_nxt[7:0]   = data_byte;
    if (pos == 17'd17) stored_crc_nxt[15:8]  = data_byte;
    if (pos == 17'd18) stored_crc_nxt[23:16] = data_byte;
    if (pos == 17'd19) stored_crc_nxt[31:24] = data_byte;

    // stored CRC bytes are skipped by the CRC span
    if (pos < 17'd16 || pos >= 17'(HDR_BYTES)) crc_nxt = crc_byte(crc_r, data_byte);

    // conversation id sits at the payload start
    if (cfg.check_enable) begin
      conv_hit  = (pos >= 17'(HDR_BYTES)) && (pos < 17'(HDR_BYTES + 4));
      conv_lane = 2'(pos - 17'(HDR_BYTES));
    end else begin
      conv_hit  = (pos < 17'd4);
      conv_lane = pos[1:0];
    end
    if (conv_hit) begin
      unique case (conv_lane)
        2'd0: conv_nxt[7:0]   = data_byte;
        2'd1: conv_nxt[15:8]  = data_byte;
        2'd2: conv_nxt[23:16] = data_byte;
        2'd3: conv_nxt[31:24] = data_byte;
        default: conv_nxt = conv_r;
      endcase
    end

    byte_cnt_nxt = (byte_cnt_r < COUNT_MAX) ? byte_cnt_r + 17'd1 : byte_cnt_r;
  end

  assign total     = byte_cnt_nxt;
  assign max_total = {1'b0, cfg.max_payload} + 17'(HDR_BYTES);
  assign len_total = {1'b0, hdr_len_nxt} + 17'(HDR_BYTES);

  // Verdict at the last byte
  always_comb begin
    pass_nxt = pass_r;
    fail_nxt = fail_r;
    result.session_id = 32'd0;
    if (cfg.check_enable) begin
      plen_full = (total >= 17'(HDR_BYTES)) ? total - 17'(HDR_BYTES) : 17'd0;
      if (total < 17'(HDR_BYTES)) begin
        result.status = ST_TOO_SHORT;
      end else begin
        result.session_id = hdr_sess_nxt;
        priority if (total > max_total) begin
          result.status = ST_TOO_LONG;
        end else if (magic_nxt != FRAME_MAGIC) begin
          result.status = ST_BAD_MAGIC;
          fail_nxt = fail_r + COUNTER_BITS'(1);
        end else if (len_total != total) begin
          result.status = ST_LEN_MISMATCH;
          fail_nxt = fail_r + COUNTER_BITS'(1);
        end else if (~crc_nxt != stored_crc_nxt) begin
          result.status = ST_CRC_MISMATCH;
          fail_nxt = fail_r + COUNTER_BITS'(1);
        end else begin
          pass_nxt = pass_r + COUNTER_BITS'(1);
          result.status = (plen_full < 17'd4) ? ST_NO_CONV_ID : ST_OK;
        end
      end
    end else begin
      plen_full = total;
      result.status = (total < 17'd4) ? ST_NO_CONV_ID : ST_OK;
    end
    result.conversation_id = (result.status == ST_OK) ? conv_nxt : 32'd0;
    result.payload_length  = plen_full[16] ? 16'hFFFF : plen_full[15:0];
    pass_ext = {32'd0, pass_nxt};
    fail_ext = {32'd0, fail_nxt};
    result.pass_count = pass_ext[31:0];
    result.fail_count = fail_ext[31:0];
  end

  // Frame state clears after each verdict; counters persist
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r   <= '0;
      crc_r        <= CRC_INIT;
      magic_r      <= '0;
      hdr_len_r    <= '0;
      hdr_sess_r   <= '0;
      stored_crc_r <= '0;
      conv_r       <= '0;
      pass_r       <= '0;
      fail_r       <= '0;
    end else if (byte_go) begin
      if (last_byte) begin
        byte_cnt_r   <= '0;
        crc_r        <= CRC_INIT;
        magic_r      <= '0;
        hdr_len_r    <= '0;
        hdr_sess_r   <= '0;
        stored_crc_r <= '0;
        conv_r       <= '0;
        pass_r       <= pass_nxt;
        fail_r       <= fail_nxt;
      end else begin
        byte_cnt_r   <= byte_cnt_nxt;
        crc_r        <= crc_nxt;
        magic_r      <= magic_nxt;
        hdr_len_r    <= hdr_len_nxt;
        hdr_sess_r   <= hdr_sess_nxt;
        stored_crc_r <= stored_crc_nxt;
        conv_r       <= conv_nxt;
      end
    end
  end

endmodule
